/* rtl/olisr_pkg.sv */
// shared types and constants of the ordered list block
`default_nettype none
package olisr_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned REQ_W   = 2;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CMP,
		CELL_INS,
		CELL_REM
	} cell_op_t;

	typedef struct packed {
		cell_op_t                   op;
		logic signed [VALUE_W-1:0] key;
	} cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/olisr_cell.sv */
// one list slot: stored value, valid flag and compare hit
`default_nettype none
module olisr_cell (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire olisr_pkg::cell_ctl_t               ctl,
	input  wire logic                               remove_here,
	input  wire logic signed [olisr_pkg::VALUE_W-1:0] prev_value,
	input  wire logic                               prev_valid,
	input  wire logic signed [olisr_pkg::VALUE_W-1:0] next_value,
	input  wire logic                               next_valid,
	output logic signed [olisr_pkg::VALUE_W-1:0]    value,
	output logic                                    valid,
	output logic                                    hit
);
	import olisr_pkg::*;

	logic signed [VALUE_W-1:0] value_q;
	logic                      valid_q;
	logic                      hit_q;

	// payload, no reset
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INS: value_q <= prev_value;
			CELL_REM: if (remove_here) begin
				value_q <= next_value;
			end
			default: value_q <= value_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			case (ctl.op)
				CELL_CMP: hit_q <= valid_q && (value_q == ctl.key);
				CELL_INS: valid_q <= prev_valid;
				CELL_REM: if (remove_here) begin
					valid_q <= next_valid;
				end
				default: hit_q <= hit_q;
			endcase
		end
	end

	assign value = value_q;
	assign valid = valid_q;
	assign hit   = hit_q;

endmodule
`default_nettype wire

/* rtl/olisr_prefix.sv */
// log-depth prefix or over cell hits and index of the first hit
`default_nettype none
module olisr_prefix #(
	parameter int unsigned N = 16
) (
	input  wire logic [N-1:0]         hit,
	output logic [N-1:0]              incl,
	output logic                      any_hit,
	output logic [$clog2(N)-1:0]      first_idx
);
	localparam int unsigned LV = $clog2(N);

	logic [N-1:0] lvl [0:LV];
	logic [N-1:0] first;
	logic [N-1:0] sel [0:LV-1];

	assign lvl[0] = hit;

	genvar l, i, b;
	generate
		for (l = 0; l < LV; l++) begin : g_lvl
			for (i = 0; i < N; i++) begin : g_or
				if (i >= (1 << l)) begin : g_take
					assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1 << l)];
				end else begin : g_keep
					assign lvl[l+1][i] = lvl[l][i];
				end
			end
		end

		for (i = 0; i < N; i++) begin : g_first
			if (i == 0) begin : g_head
				assign first[i] = hit[i];
			end else begin : g_rest
				assign first[i] = hit[i] & ~lvl[LV][i-1];
			end
		end

		// each index bit is the or of one-hot positions that carry it
		for (b = 0; b < LV; b++) begin : g_enc
			for (i = 0; i < N; i++) begin : g_sel
				if (((i >> b) & 1) == 1) begin : g_on
					assign sel[b][i] = first[i];
				end else begin : g_off
					assign sel[b][i] = 1'b0;
				end
			end
			assign first_idx[b] = |sel[b];
		end
	endgenerate

	assign incl    = lvl[LV];
	assign any_hit = lvl[LV][N-1];

endmodule
`default_nettype wire

/* rtl/ordered_list_insert_search_remove.sv */
// top level of the bounded most-recent-first list with insert, search and remove
//
// request channel: req_valid/req_ready carries one beat of req_type and
// item_value; 0 inserts at the head, 1 searches, 2 removes the first match
// from the head, 3 leaves the list alone and only reports count and emptiness.
// response channel: rsp_valid/rsp_ready carries one beat per request with
// found, position, dropped, entry_count and is_empty.
// each request passes the idle state, which takes the beat, the compare
// state, in which every cell compares its value with the key, and the
// update state, in which the prefix-or over the cell hits picks the first
// match and the cells shift (down on insert, up behind the match on remove)
// while the response register loads. a new request beat is taken only once
// the update state is done, so a request is finished before the next starts.
// the response register frees the request side: a new beat is taken while
// an earlier response still waits; if the receiver stalls, the next request
// waits in its update cycle until the response register is free.
// reset clears the valid flag of every cell and the entry count, so the
// list starts empty; stored values are not cleared.
`default_nettype none
module ordered_list_insert_search_remove #(
	parameter int unsigned LIST_DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 req_valid,
	output logic                                      req_ready,
	input  wire logic [olisr_pkg::REQ_W-1:0]          req_type,
	input  wire logic signed [olisr_pkg::VALUE_W-1:0] item_value,
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_ready,
	output logic                                      found,
	output logic [olisr_pkg::POS_W-1:0]               position,
	output logic                                      dropped,
	output logic [olisr_pkg::CNT_W-1:0]               entry_count,
	output logic                                      is_empty
);
	import olisr_pkg::*;

	localparam int unsigned IW = $clog2(LIST_DEPTH);
	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	state_t                    state_q;
	logic [REQ_W-1:0]          req_q;
	logic signed [VALUE_W-1:0] key_q;
	logic [CW-1:0]             count_q;

	// response register
	logic                      rsp_valid_q;
	logic                      found_q;
	logic [POS_W-1:0]          position_q;
	logic                      dropped_q;
	logic [CNT_W-1:0]          count_out_q;
	logic                      empty_q;

	// cell chain
	logic signed [VALUE_W-1:0] cell_value [0:LIST_DEPTH-1];
	logic [LIST_DEPTH-1:0]     cell_valid;
	logic [LIST_DEPTH-1:0]     cell_hit;
	logic [LIST_DEPTH-1:0]     incl;
	logic                      any_hit;
	logic [IW-1:0]             first_idx;
	cell_ctl_t                 ctl;

	logic                      req_fire;
	logic                      upd_go;
	logic                      full;
	logic                      do_ins;
	logic                      do_rem;
	logic                      is_find;
	logic [CW-1:0]             count_nxt;
	logic [IW+POS_W-1:0]       pos_ext;
	logic [CW+CNT_W-1:0]       cnt_ext;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	// update only when the response register can take the result
	assign upd_go    = (state_q == ST_UPD) && (!rsp_valid_q || rsp_ready);

	assign full    = (count_q == CW'(LIST_DEPTH));
	assign is_find = (req_q == REQ_SEARCH) || (req_q == REQ_REMOVE);
	assign do_ins  = (req_q == REQ_INSERT) && !full;
	assign do_rem  = (req_q == REQ_REMOVE) && any_hit;

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + CW'(1);
		end else if (do_rem) begin
			count_nxt = count_q - CW'(1);
		end
	end

	// both fields are reported modulo 32
	assign pos_ext = {{POS_W{1'b0}}, first_idx};
	assign cnt_ext = {{CNT_W{1'b0}}, count_nxt};

	// broadcast command to every cell
	always_comb begin
		ctl.key = key_q;
		ctl.op  = CELL_HOLD;
		if (state_q == ST_CMP) begin
			ctl.op = CELL_CMP;
		end else if (upd_go && do_ins) begin
			ctl.op = CELL_INS;
		end else if (upd_go && do_rem) begin
			ctl.op = CELL_REM;
		end
	end

	genvar i;
	generate
		for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
			logic signed [VALUE_W-1:0] prev_value;
			logic                      prev_valid;
			logic signed [VALUE_W-1:0] next_value;
			logic                      next_valid;

			// head takes the key on insert
			if (i == 0) begin : g_head
				assign prev_value = key_q;
				assign prev_valid = 1'b1;
			end else begin : g_mid
				assign prev_value = cell_value[i-1];
				assign prev_valid = cell_valid[i-1];
			end

			// tail empties on remove
			if (i == LIST_DEPTH - 1) begin : g_tail
				assign next_value = '0;
				assign next_valid = 1'b0;
			end else begin : g_body
				assign next_value = cell_value[i+1];
				assign next_valid = cell_valid[i+1];
			end

			olisr_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.remove_here (incl[i]),
				.prev_value  (prev_value),
				.prev_valid  (prev_valid),
				.next_value  (next_value),
				.next_valid  (next_valid),
				.value       (cell_value[i]),
				.valid       (cell_valid[i]),
				.hit         (cell_hit[i])
			);
		end
	endgenerate

	// first match and everything behind it
	olisr_prefix #(
		.N (LIST_DEPTH)
	) u_prefix (
		.hit       (cell_hit),
		.incl      (incl),
		.any_hit   (any_hit),
		.first_idx (first_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= REQ_INSERT;
			key_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			position_q  <= '0;
			dropped_q   <= 1'b0;
			count_out_q <= '0;
			empty_q     <= 1'b1;
		end else begin
			// a beat taken while a new result loads keeps valid high
			if (rsp_valid_q && rsp_ready && !upd_go) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (req_fire) begin
					req_q   <= req_type;
					key_q   <= item_value;
					state_q <= ST_CMP;
				end
				ST_CMP: state_q <= ST_UPD;
				ST_UPD: if (upd_go) begin
					count_q     <= count_nxt;
					rsp_valid_q <= 1'b1;
					found_q     <= is_find && any_hit;
					position_q  <= (is_find && any_hit) ? pos_ext[POS_W-1:0] : '0;
					dropped_q   <= (req_q == REQ_INSERT) && full;
					count_out_q <= cnt_ext[CNT_W-1:0];
					empty_q     <= (count_nxt == '0);
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign found       = found_q;
	assign position    = position_q;
	assign dropped     = dropped_q;
	assign entry_count = count_out_q;
	assign is_empty    = empty_q;

endmodule
`default_nettype wire
